// ----- design/spi_pkg.sv -----
// Shared types and constants for the segment/plane intersection pipeline.
// No dependencies.
package spi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int LEN_W     = 64;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        KIND_MISS  = 2'd0,
        KIND_BEGIN = 2'd1,
        KIND_END   = 2'd2,
        KIND_CROSS = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_A = 8'd0,
        REG_PLANE_B = 8'd1,
        REG_PLANE_C = 8'd2,
        REG_PLANE_D = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } diff_t;

    // Request carried alongside the divider: base point, direction, outcome.
    typedef struct packed {
        kind_t  kind;
        point_t base;
        diff_t  diff;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] d;
    } plane_t;

    function automatic logic signed [LEN_W-1:0] mul32(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        logic signed [LEN_W-1:0] r;
        r = LEN_W'(p) * LEN_W'(q);
        return r;
    endfunction

endpackage

// ----- design/spi_eval.sv -----
// Plane evaluation at both endpoints and outcome classification (3 stages).
// Depends on spi_pkg.
module spi_eval #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  spi_pkg::plane_t                   plane,
    input  logic                              in_valid,
    input  spi_pkg::point_t                   in_begin,
    input  spi_pkg::point_t                   in_end,
    output logic                              out_valid,
    output logic [spi_pkg::LEN_W-1:0]         out_rem,
    output logic [spi_pkg::LEN_W-1:0]         out_den,
    output spi_pkg::item_t                    out_item
);
    localparam int LW = spi_pkg::LEN_W;

    // stage 1: products
    logic                 v1_reg;
    logic signed [LW-1:0] pb_reg [3];
    logic signed [LW-1:0] pe_reg [3];
    spi_pkg::point_t      b1_reg, e1_reg;
    // stage 2: plane values
    logic                 v2_reg;
    logic signed [LW-1:0] len1_reg, len2_reg;
    spi_pkg::point_t      b2_reg, e2_reg;
    // stage 3: classification
    logic                 v3_reg;
    logic [LW-1:0]        rem_reg, den_reg;
    spi_pkg::item_t       item_reg;

    logic signed [LW-1:0] d_ext;
    logic signed [LW-1:0] len1_next, len2_next;
    logic [LW-1:0]        m1, m2;
    spi_pkg::item_t       item_next;

    assign d_ext = LW'(plane.d);

    assign len1_next = (pb_reg[0] >>> FRAC_BITS) + (pb_reg[1] >>> FRAC_BITS)
                     + (pb_reg[2] >>> FRAC_BITS) + d_ext;
    assign len2_next = (pe_reg[0] >>> FRAC_BITS) + (pe_reg[1] >>> FRAC_BITS)
                     + (pe_reg[2] >>> FRAC_BITS) + d_ext;

    assign m1 = len1_reg[LW-1] ? LW'(-len1_reg) : LW'(len1_reg);
    assign m2 = len2_reg[LW-1] ? LW'(-len2_reg) : LW'(len2_reg);

    always_comb begin
        item_next.kind = spi_pkg::KIND_MISS;
        item_next.base = '0;
        item_next.diff = '0;
        if (len1_reg == '0) begin
            item_next.kind = spi_pkg::KIND_BEGIN;
            item_next.base = b2_reg;
        end else if (len2_reg == '0) begin
            item_next.kind = spi_pkg::KIND_END;
            item_next.base = e2_reg;
        end else if (len1_reg[LW-1] != len2_reg[LW-1]) begin
            item_next.kind   = spi_pkg::KIND_CROSS;
            item_next.base   = b2_reg;
            item_next.diff.x = spi_pkg::DIFF_W'(e2_reg.x) - spi_pkg::DIFF_W'(b2_reg.x);
            item_next.diff.y = spi_pkg::DIFF_W'(e2_reg.y) - spi_pkg::DIFF_W'(b2_reg.y);
            item_next.diff.z = spi_pkg::DIFF_W'(e2_reg.z) - spi_pkg::DIFF_W'(b2_reg.z);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pb_reg[0] <= spi_pkg::mul32(plane.a, in_begin.x);
            pb_reg[1] <= spi_pkg::mul32(plane.b, in_begin.y);
            pb_reg[2] <= spi_pkg::mul32(plane.c, in_begin.z);
            pe_reg[0] <= spi_pkg::mul32(plane.a, in_end.x);
            pe_reg[1] <= spi_pkg::mul32(plane.b, in_end.y);
            pe_reg[2] <= spi_pkg::mul32(plane.c, in_end.z);
            b1_reg    <= in_begin;
            e1_reg    <= in_end;
            len1_reg  <= len1_next;
            len2_reg  <= len2_next;
            b2_reg    <= b1_reg;
            e2_reg    <= e1_reg;
            rem_reg   <= m1;
            den_reg   <= m1 + m2;
            item_reg  <= item_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_item  = item_reg;
endmodule

// ----- design/spi_div_step.sv -----
// One registered restoring-division step producing one quotient bit.
// Depends on spi_pkg.
module spi_div_step #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [spi_pkg::LEN_W-1:0]   in_rem,
    input  logic [spi_pkg::LEN_W-1:0]   in_den,
    input  logic [FRAC_BITS-1:0]        in_q,
    input  spi_pkg::item_t              in_item,
    output logic                        out_valid,
    output logic [spi_pkg::LEN_W-1:0]   out_rem,
    output logic [spi_pkg::LEN_W-1:0]   out_den,
    output logic [FRAC_BITS-1:0]        out_q,
    output spi_pkg::item_t              out_item
);
    localparam int LW = spi_pkg::LEN_W;

    logic                 valid_reg;
    logic [LW-1:0]        rem_reg, den_reg;
    logic [FRAC_BITS-1:0] q_reg;
    spi_pkg::item_t       item_reg;

    logic [LW-1:0] rem2;
    logic          take;

    assign rem2 = {in_rem[LW-2:0], 1'b0};
    assign take = rem2 >= in_den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= take ? rem2 - in_den : rem2;
            den_reg  <= in_den;
            q_reg    <= {in_q[FRAC_BITS-2:0], take};
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;
    assign out_item  = item_reg;
endmodule

// ----- design/spi_lerp.sv -----
// Crossing point base + floor(diff * t), two stages, the second of which is the output register.
// Depends on spi_pkg.
module spi_lerp #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [FRAC_BITS-1:0]               in_t,
    input  spi_pkg::item_t                     in_item,
    output logic                               out_valid,
    output logic                               out_hit,
    output logic [1:0]                         out_kind,
    output spi_pkg::point_t                    out_point
);
    localparam int DW = spi_pkg::DIFF_W;
    localparam int PW = DW + FRAC_BITS + 1;
    localparam int CW = spi_pkg::COORD_W;

    logic                 v1_reg, v2_reg;
    logic signed [PW-1:0] px_reg, py_reg, pz_reg;
    spi_pkg::item_t       item_reg;
    logic                 hit_reg;
    logic [1:0]           kind_reg;
    spi_pkg::point_t      point_reg;

    logic signed [FRAC_BITS:0] t_s;
    logic signed [PW-1:0]      sx, sy, sz;

    assign t_s = {1'b0, in_t};
    assign sx  = px_reg >>> FRAC_BITS;
    assign sy  = py_reg >>> FRAC_BITS;
    assign sz  = pz_reg >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg      <= PW'(in_item.diff.x) * PW'(t_s);
            py_reg      <= PW'(in_item.diff.y) * PW'(t_s);
            pz_reg      <= PW'(in_item.diff.z) * PW'(t_s);
            item_reg    <= in_item;
            hit_reg     <= item_reg.kind != spi_pkg::KIND_MISS;
            kind_reg    <= item_reg.kind;
            point_reg.x <= item_reg.base.x + sx[CW-1:0];
            point_reg.y <= item_reg.base.y + sy[CW-1:0];
            point_reg.z <= item_reg.base.z + sz[CW-1:0];
        end
    end

    assign out_valid = v2_reg;
    assign out_hit   = hit_reg;
    assign out_kind  = kind_reg;
    assign out_point = point_reg;
endmodule

// ----- design/segment_plane_intersection.sv -----
// Top level: segment/plane intersection pipeline with plane registers.
// Depends on spi_pkg, spi_eval, spi_div_step, spi_lerp.

// One request per cycle while m_ready does not stall, fully pipelined through three evaluation
// stages, one divider stage per quotient bit and two interpolation stages.
// A stall on m_ready freezes the whole pipeline.
// Plane registers should be written only while no request is in flight.
module segment_plane_intersection #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [spi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [spi_pkg::COORD_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [spi_pkg::COORD_W-1:0]    s_begin_x,
    input  logic signed [spi_pkg::COORD_W-1:0]    s_begin_y,
    input  logic signed [spi_pkg::COORD_W-1:0]    s_begin_z,
    input  logic signed [spi_pkg::COORD_W-1:0]    s_end_x,
    input  logic signed [spi_pkg::COORD_W-1:0]    s_end_y,
    input  logic signed [spi_pkg::COORD_W-1:0]    s_end_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [1:0]                            m_hit_kind,
    output logic signed [spi_pkg::COORD_W-1:0]    m_point_x,
    output logic signed [spi_pkg::COORD_W-1:0]    m_point_y,
    output logic signed [spi_pkg::COORD_W-1:0]    m_point_z
);
    localparam int LW = spi_pkg::LEN_W;

    spi_pkg::plane_t plane_reg;
    logic            en;
    spi_pkg::point_t in_begin, in_end, out_point;

    logic                 dv   [FRAC_BITS+1];
    logic [LW-1:0]        drem [FRAC_BITS+1];
    logic [LW-1:0]        dden [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] dq   [FRAC_BITS+1];
    spi_pkg::item_t       ditem[FRAC_BITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                spi_pkg::REG_PLANE_A: plane_reg.a <= cfg_wdata;
                spi_pkg::REG_PLANE_B: plane_reg.b <= cfg_wdata;
                spi_pkg::REG_PLANE_C: plane_reg.c <= cfg_wdata;
                spi_pkg::REG_PLANE_D: plane_reg.d <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign in_begin = '{x: s_begin_x, y: s_begin_y, z: s_begin_z};
    assign in_end   = '{x: s_end_x, y: s_end_y, z: s_end_z};

    spi_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .plane    (plane_reg),
        .in_valid (s_valid),
        .in_begin (in_begin),
        .in_end   (in_end),
        .out_valid(dv[0]),
        .out_rem  (drem[0]),
        .out_den  (dden[0]),
        .out_item (ditem[0])
    );

    assign dq[0] = '0;

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
        spi_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dv[i]),
            .in_rem   (drem[i]),
            .in_den   (dden[i]),
            .in_q     (dq[i]),
            .in_item  (ditem[i]),
            .out_valid(dv[i+1]),
            .out_rem  (drem[i+1]),
            .out_den  (dden[i+1]),
            .out_q    (dq[i+1]),
            .out_item (ditem[i+1])
        );
    end

    spi_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dv[FRAC_BITS]),
        .in_t     (dq[FRAC_BITS]),
        .in_item  (ditem[FRAC_BITS]),
        .out_valid(m_valid),
        .out_hit  (m_hit),
        .out_kind (m_hit_kind),
        .out_point(out_point)
    );

    assign m_point_x = out_point.x;
    assign m_point_y = out_point.y;
    assign m_point_z = out_point.z;
endmodule
